// ===== rtl/cac_pkg.sv =====
package cac_pkg;

   // Threshold register width and the width of its square.
   localparam int DIST_WIDTH = 24;
   localparam int T2_WIDTH   = 2 * DIST_WIDTH;
   localparam int T2_HALF    = DIST_WIDTH;

   // Register stages from input beat to output register.
   localparam int NUM_STAGES = 7;

   // Decisions that ride along with the wide products.
   typedef struct packed {
      logic near;      // already closer than the threshold
      logic approach;  // relative motion closes the gap
   } flags_type;

endpackage

// ===== rtl/closest_approach_collision_check.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  positions and velocities of both bodies
// rsp_      out        rsp_valid / rsp_stall  rsp_collision_flag
// csr_      in         csr_write_enable       csr_write_data, threshold distance
//
// Seven register stages; one beat enters per cycle while req_stall is low, and its
// result is valid when it reaches the output register. The depth is set by the split
// squaring of the 46-bit cross product.
// Reset clears the stage valid bits and the threshold (flag reads 0 until it is written).
// A stalled result holds in the output register; earlier stages keep moving into empty
// slots, and req_stall rises only when every stage up to the input holds a beat.
module closest_approach_collision_check #(
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [POS_WIDTH-1:0]         req_person_x,
   input  logic signed [POS_WIDTH-1:0]         req_person_y,
   input  logic signed [POS_WIDTH-1:0]         req_vehicle_x,
   input  logic signed [POS_WIDTH-1:0]         req_vehicle_y,
   input  logic signed [VEL_WIDTH-1:0]         req_person_vx,
   input  logic signed [VEL_WIDTH-1:0]         req_person_vy,
   input  logic signed [VEL_WIDTH-1:0]         req_vehicle_vx,
   input  logic signed [VEL_WIDTH-1:0]         req_vehicle_vy,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_collision_flag,
   input  logic                                csr_write_enable,
   input  logic [cac_pkg::DIST_WIDTH-1:0]      csr_write_data
);

   import cac_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, valid_shift, stage_en;
   logic [T2_WIDTH-1:0]   t2_ff, t2_in;

   logic signed [2*POS_WIDTH+1:0]         pxx, pyy;
   logic signed [2*VEL_WIDTH+1:0]         vxx, vyy;
   logic signed [POS_WIDTH+VEL_WIDTH+1:0] pxvx, pyvy, pxvy, pyvx;
   flags_type                             flags;
   logic [POS_WIDTH+VEL_WIDTH+1:0]        cross_mag;
   logic [2*VEL_WIDTH+1:0]                speed_sq;

   // The squared threshold is formed once, when the register is written.
   assign t2_in = csr_write_enable ? (T2_WIDTH'(csr_write_data) * T2_WIDTH'(csr_write_data))
                                   : t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff <= '0;
      end else begin
         t2_ff <= t2_in;
      end
   end

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_shift = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign valid_in    = (stage_en & valid_shift) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // Differences and products.
   cac_front #(
      .POS_WIDTH (POS_WIDTH),
      .VEL_WIDTH (VEL_WIDTH)
   ) u_front (
      .clock      (clock),
      .stage_en   (stage_en[1:0]),
      .person_x   (req_person_x),
      .person_y   (req_person_y),
      .vehicle_x  (req_vehicle_x),
      .vehicle_y  (req_vehicle_y),
      .person_vx  (req_person_vx),
      .person_vy  (req_person_vy),
      .vehicle_vx (req_vehicle_vx),
      .vehicle_vy (req_vehicle_vy),
      .pxx        (pxx),
      .pyy        (pyy),
      .vxx        (vxx),
      .vyy        (vyy),
      .pxvx       (pxvx),
      .pyvy       (pyvy),
      .pxvy       (pxvy),
      .pyvx       (pyvx)
   );

   // Sums, threshold test and approach sign.
   cac_sum #(
      .POS_WIDTH (POS_WIDTH),
      .VEL_WIDTH (VEL_WIDTH)
   ) u_sum (
      .clock     (clock),
      .stage_en  (stage_en[3:2]),
      .t2        (t2_ff),
      .pxx       (pxx),
      .pyy       (pyy),
      .vxx       (vxx),
      .vyy       (vyy),
      .pxvx      (pxvx),
      .pyvy      (pyvy),
      .pxvy      (pxvy),
      .pyvx      (pyvx),
      .flags     (flags),
      .cross_mag (cross_mag),
      .speed_sq  (speed_sq)
   );

   // Wide closest-gap comparison and output register.
   cac_square_cmp #(
      .POS_WIDTH (POS_WIDTH),
      .VEL_WIDTH (VEL_WIDTH)
   ) u_square_cmp (
      .clock     (clock),
      .stage_en  (stage_en[6:4]),
      .t2        (t2_ff),
      .flags     (flags),
      .cross_mag (cross_mag),
      .speed_sq  (speed_sq),
      .hit       (rsp_collision_flag)
   );

endmodule

// ===== rtl/cac_front.sv =====
module cac_front #(
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 20
) (
   input  logic                                 clock,
   input  logic [1:0]                           stage_en,
   input  logic signed [POS_WIDTH-1:0]          person_x,
   input  logic signed [POS_WIDTH-1:0]          person_y,
   input  logic signed [POS_WIDTH-1:0]          vehicle_x,
   input  logic signed [POS_WIDTH-1:0]          vehicle_y,
   input  logic signed [VEL_WIDTH-1:0]          person_vx,
   input  logic signed [VEL_WIDTH-1:0]          person_vy,
   input  logic signed [VEL_WIDTH-1:0]          vehicle_vx,
   input  logic signed [VEL_WIDTH-1:0]          vehicle_vy,
   output logic signed [2*POS_WIDTH+1:0]        pxx,
   output logic signed [2*POS_WIDTH+1:0]        pyy,
   output logic signed [2*VEL_WIDTH+1:0]        vxx,
   output logic signed [2*VEL_WIDTH+1:0]        vyy,
   output logic signed [POS_WIDTH+VEL_WIDTH+1:0] pxvx,
   output logic signed [POS_WIDTH+VEL_WIDTH+1:0] pyvy,
   output logic signed [POS_WIDTH+VEL_WIDTH+1:0] pxvy,
   output logic signed [POS_WIDTH+VEL_WIDTH+1:0] pyvx
);

   localparam int DPW = POS_WIDTH + 1;
   localparam int DVW = VEL_WIDTH + 1;

   logic signed [DPW-1:0] dpx_in, dpy_in, dpx_ff, dpy_ff;
   logic signed [DVW-1:0] dvx_in, dvy_in, dvx_ff, dvy_ff;

   logic signed [2*DPW-1:0]   pxx_in, pyy_in, pxx_ff, pyy_ff;
   logic signed [2*DVW-1:0]   vxx_in, vyy_in, vxx_ff, vyy_ff;
   logic signed [DPW+DVW-1:0] pxvx_in, pyvy_in, pxvy_in, pyvx_in;
   logic signed [DPW+DVW-1:0] pxvx_ff, pyvy_ff, pxvy_ff, pyvx_ff;

   // Relative position and velocity, one bit wider than the operands.
   assign dpx_in = $signed({person_x[POS_WIDTH-1], person_x})
                 - $signed({vehicle_x[POS_WIDTH-1], vehicle_x});
   assign dpy_in = $signed({person_y[POS_WIDTH-1], person_y})
                 - $signed({vehicle_y[POS_WIDTH-1], vehicle_y});
   assign dvx_in = $signed({person_vx[VEL_WIDTH-1], person_vx})
                 - $signed({vehicle_vx[VEL_WIDTH-1], vehicle_vx});
   assign dvy_in = $signed({person_vy[VEL_WIDTH-1], person_vy})
                 - $signed({vehicle_vy[VEL_WIDTH-1], vehicle_vy});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dpx_ff <= dpx_in;
         dpy_ff <= dpy_in;
         dvx_ff <= dvx_in;
         dvy_ff <= dvy_in;
      end
   end

   // All eight signed products, each a single multiplier.
   assign pxx_in  = dpx_ff * dpx_ff;
   assign pyy_in  = dpy_ff * dpy_ff;
   assign vxx_in  = dvx_ff * dvx_ff;
   assign vyy_in  = dvy_ff * dvy_ff;
   assign pxvx_in = dpx_ff * dvx_ff;
   assign pyvy_in = dpy_ff * dvy_ff;
   assign pxvy_in = dpx_ff * dvy_ff;
   assign pyvx_in = dpy_ff * dvx_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         pxx_ff  <= pxx_in;
         pyy_ff  <= pyy_in;
         vxx_ff  <= vxx_in;
         vyy_ff  <= vyy_in;
         pxvx_ff <= pxvx_in;
         pyvy_ff <= pyvy_in;
         pxvy_ff <= pxvy_in;
         pyvx_ff <= pyvx_in;
      end
   end

   assign pxx  = pxx_ff;
   assign pyy  = pyy_ff;
   assign vxx  = vxx_ff;
   assign vyy  = vyy_ff;
   assign pxvx = pxvx_ff;
   assign pyvy = pyvy_ff;
   assign pxvy = pxvy_ff;
   assign pyvx = pyvx_ff;

endmodule

// ===== rtl/cac_sum.sv =====
module cac_sum #(
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic [1:0]                            stage_en,
   input  logic [cac_pkg::T2_WIDTH-1:0]          t2,
   input  logic signed [2*POS_WIDTH+1:0]         pxx,
   input  logic signed [2*POS_WIDTH+1:0]         pyy,
   input  logic signed [2*VEL_WIDTH+1:0]         vxx,
   input  logic signed [2*VEL_WIDTH+1:0]         vyy,
   input  logic signed [POS_WIDTH+VEL_WIDTH+1:0] pxvx,
   input  logic signed [POS_WIDTH+VEL_WIDTH+1:0] pyvy,
   input  logic signed [POS_WIDTH+VEL_WIDTH+1:0] pxvy,
   input  logic signed [POS_WIDTH+VEL_WIDTH+1:0] pyvx,
   output cac_pkg::flags_type                    flags,
   output logic [POS_WIDTH+VEL_WIDTH+1:0]        cross_mag,
   output logic [2*VEL_WIDTH+1:0]                speed_sq
);

   import cac_pkg::*;

   localparam int DW   = 2 * POS_WIDTH + 2;         // |dp|^2
   localparam int SW   = 2 * VEL_WIDTH + 2;         // |dv|^2
   localparam int CSW  = POS_WIDTH + VEL_WIDTH + 3; // signed dot and cross
   localparam int CW   = CSW - 1;                   // cross magnitude
   localparam int NCW  = (DW > T2_WIDTH) ? DW : T2_WIDTH;

   logic signed [DW:0]    d2_sum;
   logic signed [SW:0]    s_sum;
   logic [DW-1:0]         d2_in, d2_ff;
   logic [SW-1:0]         s_in, s_ff, s2_ff;
   logic signed [CSW-1:0] dot_in, dot_ff, cross_in, cross_ff, cross_abs;
   logic [CW-1:0]         cm_in, cm_ff;
   flags_type             flags_in, flags_ff;

   // Squared lengths are never negative, so the sign bit is dropped.
   assign d2_sum   = pxx + pyy;
   assign s_sum    = vxx + vyy;
   assign d2_in    = d2_sum[DW-1:0];
   assign s_in     = s_sum[SW-1:0];
   assign dot_in   = pxvx + pyvy;
   assign cross_in = pxvy - pyvx;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d2_ff    <= d2_in;
         s_ff     <= s_in;
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
      end
   end

   // Threshold test, approach sign and the cross product's magnitude.
   assign cross_abs         = cross_ff[CSW-1] ? -cross_ff : cross_ff;
   assign cm_in             = cross_abs[CW-1:0];
   assign flags_in.near     = NCW'(d2_ff) < NCW'(t2);
   assign flags_in.approach = dot_ff[CSW-1];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         flags_ff <= flags_in;
         cm_ff    <= cm_in;
         s2_ff    <= s_ff;
      end
   end

   assign flags     = flags_ff;
   assign cross_mag = cm_ff;
   assign speed_sq  = s2_ff;

endmodule

// ===== rtl/cac_square_cmp.sv =====
module cac_square_cmp #(
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 20
) (
   input  logic                           clock,
   input  logic [2:0]                     stage_en,
   input  logic [cac_pkg::T2_WIDTH-1:0]   t2,
   input  cac_pkg::flags_type             flags,
   input  logic [POS_WIDTH+VEL_WIDTH+1:0] cross_mag,
   input  logic [2*VEL_WIDTH+1:0]         speed_sq,
   output logic                           hit
);

   import cac_pkg::*;

   localparam int CW   = POS_WIDTH + VEL_WIDTH + 2;
   localparam int H    = (CW + 1) / 2;
   localparam int SW   = 2 * VEL_WIDTH + 2;
   localparam int SH   = (SW + 1) / 2;
   localparam int C2W  = 2 * CW;
   localparam int RW   = T2_WIDTH + SW;
   localparam int CMPW = (C2W > RW) ? C2W : RW;
   localparam int THW  = T2_WIDTH - T2_HALF;

   logic [CW-H-1:0]       ch;
   logic [H-1:0]          cl;
   logic [SW-SH-1:0]      sh;
   logic [SH-1:0]         sl;
   logic [THW-1:0]        th;
   logic [T2_HALF-1:0]    tl;

   logic [2*(CW-H)-1:0]   aa_in, aa_ff;
   logic [CW-1:0]         ab_in, ab_ff;
   logic [2*H-1:0]        bb_in, bb_ff;
   logic [THW+SW-SH-1:0]  ths_in, ths_ff;
   logic [THW+SH-1:0]     tls_in, tls_ff;
   logic [T2_HALF+SW-SH-1:0] tlh_in, tlh_ff;
   logic [T2_HALF+SH-1:0] tll_in, tll_ff;
   flags_type             f5_ff, f6_ff;

   logic [CMPW-1:0]       c2_in, c2_ff, rhs_in, rhs_ff;
   logic                  hit_in, hit_ff;

   // Split the three wide operands into halves that fit ordinary multipliers.
   assign ch = cross_mag[CW-1:H];
   assign cl = cross_mag[H-1:0];
   assign sh = speed_sq[SW-1:SH];
   assign sl = speed_sq[SH-1:0];
   assign th = t2[T2_WIDTH-1:T2_HALF];
   assign tl = t2[T2_HALF-1:0];

   assign aa_in  = ch * ch;
   assign ab_in  = ch * cl;
   assign bb_in  = cl * cl;
   assign ths_in = th * sh;
   assign tls_in = th * sl;
   assign tlh_in = tl * sh;
   assign tll_in = tl * sl;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         aa_ff  <= aa_in;
         ab_ff  <= ab_in;
         bb_ff  <= bb_in;
         ths_ff <= ths_in;
         tls_ff <= tls_in;
         tlh_ff <= tlh_in;
         tll_ff <= tll_in;
         f5_ff  <= flags;
      end
   end

   // Recombine the partial products into cross^2 and T^2 * s.
   assign c2_in  = (CMPW'(aa_ff) << (2 * H)) + (CMPW'(ab_ff) << (H + 1)) + CMPW'(bb_ff);
   assign rhs_in = (CMPW'(ths_ff) << (T2_HALF + SH)) + (CMPW'(tls_ff) << T2_HALF)
                 + (CMPW'(tlh_ff) << SH) + CMPW'(tll_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         c2_ff  <= c2_in;
         rhs_ff <= rhs_in;
         f6_ff  <= f5_ff;
      end
   end

   // Final decision into the output register.
   assign hit_in = f6_ff.near || (f6_ff.approach && (c2_ff < rhs_ff));

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int POS_W = 24;
   localparam int VEL_W = 20;
   localparam int DIST_W = cac_pkg::DIST_WIDTH;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [cac_pkg::DIST_WIDTH-1:0] DIST_MAX = '1;

   // One request beat: both bodies' positions and velocities.
   typedef struct {
      logic signed [POS_W-1:0] person_x;
      logic signed [POS_W-1:0] person_y;
      logic signed [POS_W-1:0] vehicle_x;
      logic signed [POS_W-1:0] vehicle_y;
      logic signed [VEL_W-1:0] person_vx;
      logic signed [VEL_W-1:0] person_vy;
      logic signed [VEL_W-1:0] vehicle_vx;
      logic signed [VEL_W-1:0] vehicle_vy;
   } beat_type;

   // Scoreboard: holds the threshold, predicts the flag of each accepted beat
   // and compares the flags that come out in order.
   class interaction_scoreboard;
      logic [cac_pkg::DIST_WIDTH-1:0] threshold;
      bit interaction_due[$];
      int mismatches;

      function new();
         threshold = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return interaction_due.size();
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      // Exact integer closest-approach test; every product fits in 128 bits.
      function bit predict_interaction(beat_type b);
         logic signed [127:0] ex, ey, ux, uy, tsq, dist2, speed2, dotp, cross_term;
         ex = b.person_x - b.vehicle_x;
         ey = b.person_y - b.vehicle_y;
         ux = b.person_vx - b.vehicle_vx;
         uy = b.person_vy - b.vehicle_vy;
         tsq = threshold;
         tsq = tsq * tsq;
         dist2 = ex * ex + ey * ey;
         if (dist2 < tsq) return 1'b1;
         speed2 = ux * ux + uy * uy;
         if (speed2 == 0) return 1'b0;
         dotp = ex * ux + ey * uy;
         if (dotp >= 0) return 1'b0;
         cross_term = ex * uy - ey * ux;
         return (cross_term * cross_term < tsq * speed2);
      endfunction

      function void note_beat(beat_type b);
         interaction_due.insert(interaction_due.size(), predict_interaction(b));
      endfunction

      task check_flag(logic got);
         bit want;
         if (interaction_due.size() == 0) begin
            report($sformatf("flag %b arrived with nothing outstanding", got));
         end else begin
            want = interaction_due[0];
            interaction_due.delete(0);
            if (got !== want)
               report($sformatf("collision flag expected %b got %b", want, got));
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_person_x = '0;
   logic signed [POS_W-1:0] req_person_y = '0;
   logic signed [POS_W-1:0] req_vehicle_x = '0;
   logic signed [POS_W-1:0] req_vehicle_y = '0;
   logic signed [VEL_W-1:0] req_person_vx = '0;
   logic signed [VEL_W-1:0] req_person_vy = '0;
   logic signed [VEL_W-1:0] req_vehicle_vx = '0;
   logic signed [VEL_W-1:0] req_vehicle_vy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_collision_flag;
   logic csr_write_enable = 1'b0;
   logic [cac_pkg::DIST_WIDTH-1:0] csr_write_data = '0;

   interaction_scoreboard sb;
   beat_type taken_beat;
   int req_idle_pct = 38;
   int rsp_idle_pct = 63;
   int hold_left = 0;

   closest_approach_collision_check i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_person_x       (req_person_x),
      .req_person_y       (req_person_y),
      .req_vehicle_x      (req_vehicle_x),
      .req_vehicle_y      (req_vehicle_y),
      .req_person_vx      (req_person_vx),
      .req_person_vy      (req_person_vy),
      .req_vehicle_vx     (req_vehicle_vx),
      .req_vehicle_vy     (req_vehicle_vy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_collision_flag (rsp_collision_flag),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Receiver: random stalls, or a long hold-off while hold_left counts down.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Monitor: note every accepted request beat and check every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken_beat.person_x   = req_person_x;
            taken_beat.person_y   = req_person_y;
            taken_beat.vehicle_x  = req_vehicle_x;
            taken_beat.vehicle_y  = req_vehicle_y;
            taken_beat.person_vx  = req_person_vx;
            taken_beat.person_vy  = req_person_vy;
            taken_beat.vehicle_vx = req_vehicle_vx;
            taken_beat.vehicle_vy = req_vehicle_vy;
            sb.note_beat(taken_beat);
         end
         if (rsp_valid && !rsp_stall)
            sb.check_flag(rsp_collision_flag);
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic beat_type make_beat(int px, int py, int qx, int qy,
                                          int pvx, int pvy, int qvx, int qvy);
      beat_type b;
      b.person_x = POS_W'(px);
      b.person_y = POS_W'(py);
      b.vehicle_x = POS_W'(qx);
      b.vehicle_y = POS_W'(qy);
      b.person_vx = VEL_W'(pvx);
      b.person_vy = VEL_W'(pvy);
      b.vehicle_vx = VEL_W'(qvx);
      b.vehicle_vy = VEL_W'(qvy);
      return b;
   endfunction

   // Most negative, most positive, zero or minus one for a field of width w.
   function automatic int corner_value(int w);
      case ($urandom_range(0, 3))
         0: return -(1 << (w - 1));
         1: return (1 << (w - 1)) - 1;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // Random beat. Most beats place the person within a few thresholds of the
   // vehicle, and some of these aim the relative velocity roughly at it, so that the closest
   // approach lands on both sides of the threshold.
   function automatic beat_type random_beat(int unsigned radius);
      beat_type b;
      int unsigned pick, span;
      int offx, offy, big, gain, jit;
      longint rx, ry;
      pick = $urandom_range(0, 9);
      span = 3 * radius + 64;
      b.vehicle_x = POS_W'($urandom);
      b.vehicle_y = POS_W'($urandom);
      b.vehicle_vx = VEL_W'($urandom);
      b.vehicle_vy = VEL_W'($urandom);
      b.person_x = POS_W'($urandom);
      b.person_y = POS_W'($urandom);
      b.person_vx = VEL_W'($urandom);
      b.person_vy = VEL_W'($urandom);
      if (pick < 6 || pick == 9) begin
         offx = int'($urandom_range(0, 2 * span)) - int'(span);
         offy = int'($urandom_range(0, 2 * span)) - int'(span);
         b.person_x = POS_W'(b.vehicle_x + offx);
         b.person_y = POS_W'(b.vehicle_y + offy);
         gain = $urandom_range(1, 4096);
         jit = gain / int'($urandom_range(1, 16));
         big = (offx < 0) ? -offx : offx;
         if (((offy < 0) ? -offy : offy) > big) big = (offy < 0) ? -offy : offy;
         if (big == 0) big = 1;
         if (pick == 9) begin
            // Same velocity for both bodies.
            rx = 0;
            ry = 0;
         end else if (pick >= 4) begin
            rx = int'($urandom_range(0, 8192)) - 4096;
            ry = int'($urandom_range(0, 8192)) - 4096;
         end else begin
            rx = -(longint'(offx) * gain) / big + (int'($urandom_range(0, 2 * jit)) - jit);
            ry = -(longint'(offy) * gain) / big + (int'($urandom_range(0, 2 * jit)) - jit);
         end
         b.person_vx = VEL_W'(b.vehicle_vx + rx);
         b.person_vy = VEL_W'(b.vehicle_vy + ry);
      end else if (pick == 8) begin
         b.person_x = POS_W'(corner_value(POS_W));
         b.person_y = POS_W'(corner_value(POS_W));
         b.vehicle_x = POS_W'(corner_value(POS_W));
         b.vehicle_y = POS_W'(corner_value(POS_W));
         b.person_vx = VEL_W'(corner_value(VEL_W));
         b.person_vy = VEL_W'(corner_value(VEL_W));
         b.vehicle_vx = VEL_W'(corner_value(VEL_W));
         b.vehicle_vy = VEL_W'(corner_value(VEL_W));
      end
      return b;
   endfunction

   // Offer one beat after random idle cycles and hold it until accepted.
   task automatic send_beat(input beat_type b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_person_x <= b.person_x;
      req_person_y <= b.person_y;
      req_vehicle_x <= b.vehicle_x;
      req_vehicle_y <= b.vehicle_y;
      req_person_vx <= b.person_vx;
      req_person_vy <= b.person_vy;
      req_vehicle_vx <= b.vehicle_vx;
      req_vehicle_vy <= b.vehicle_vy;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every outstanding flag has arrived.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic load_threshold(input logic [cac_pkg::DIST_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.threshold = value;
   endtask

   initial begin : stimulus
      logic [cac_pkg::DIST_WIDTH-1:0] radius;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Threshold still at its reset value of zero: nothing can be flagged.
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(5, 0, 0, 0, -256, 0, 0, 0));

      // Small threshold: near, at threshold, standing, head-on, receding, tangential.
      settle();
      load_threshold(1000);
      send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(1000, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(999, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(5000, 0, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(5000, 0, 0, 0, -256, 0, 0, 0));
      send_beat(make_beat(5000, 0, 0, 0, 256, 0, 0, 0));
      send_beat(make_beat(5000, 0, 0, 0, 0, 256, 0, 0));
      send_beat(make_beat(5000, 1000, 0, 0, -256, 0, 0, 0));
      send_beat(make_beat(5000, 999, 0, 0, -256, 0, 0, 0));
      send_beat(make_beat(3000, 0, 0, 0, 300, 300, 300, 300));
      send_beat(make_beat(0, 0, 4000, -4000, 0, 0, -512, 512));

      // Largest threshold against the widest separations and speeds.
      settle();
      load_threshold(DIST_MAX);
      send_beat(make_beat(8388607, 8388607, -8388608, -8388608,
                          524287, 524287, -524288, -524288));
      send_beat(make_beat(8388607, 8388607, -8388608, -8388608,
                          -524288, -524288, 524287, 524287));
      send_beat(make_beat(8388607, -8388608, -8388608, 8388607,
                          -524288, 524287, 524287, -524288));
      send_beat(make_beat(8388607, 0, -8388608, 0, 0, 524287, 0, -524288));
      send_beat(make_beat(8388607, 0, -8388607, 0, 0, 0, 0, 0));
      send_beat(make_beat(0, 0, 0, 0, 1, 0, 0, 0));

      // Random phases, each with its own threshold and one of three idle patterns.
      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: radius = 1;
            1: radius = 1000;
            2: radius = DIST_MAX;
            3: radius = DIST_W'($urandom_range(1, DIST_MAX));
            4: radius = 300;
            5: radius = 0;
            6: radius = DIST_W'($urandom_range(1, 20000));
            default: radius = 65535;
         endcase
         if (p < 3) begin
            req_idle_pct = 38;
            rsp_idle_pct = 63;
         end else if (p < 6) begin
            req_idle_pct = 63;
            rsp_idle_pct = 38;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         load_threshold(radius);
         for (int n = 0; n < 50; n++) begin
            // Long receiver hold-off so the pipeline fills and stalls its input.
            if (n == 10 && (p == 2 || p == 7)) hold_left = 80;
            // Sender pause until the pipeline has drained.
            if (n == 25 && p == 4) settle();
            send_beat(random_beat(radius));
         end
      end

      settle();
      repeat (2 * cac_pkg::NUM_STAGES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
